// File: rtl/bor_pkg.sv
// Shared types, codes and sizes of the bitmap overlay register file.
package bor_pkg;

    localparam int PALETTE_DEPTH   = 256;
    localparam int BUSY_READ_COUNT = 4;

    localparam int DATA_W     = 16;
    localparam int OP_W       = 3;
    localparam int SEL_W      = 3;
    localparam int IDX_W      = 8;
    localparam int PAL_ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int MODE_W     = 15;
    localparam int LEN_W      = 8;
    localparam int COUNT_W    = 9;
    localparam int BUSY_CNT_W = 3;

    localparam int CTL_SWAP_BIT = 0;
    localparam int CTL_BUSY_BIT = 1;
    localparam int CTL_HBLK_BIT = 14;
    localparam int CTL_VBLK_BIT = 15;

    typedef enum logic [OP_W-1:0] {
        OP_REG_READ  = 3'd0,
        OP_REG_WRITE = 3'd1,
        OP_PAL_READ  = 3'd2,
        OP_PAL_WRITE = 3'd3,
        OP_BLANK     = 3'd4,
        OP_FILL      = 3'd5
    } op_t;

    typedef enum logic [SEL_W-1:0] {
        REG_MODE      = 3'd0,
        REG_SHIFT     = 3'd1,
        REG_FILL_LEN  = 3'd2,
        REG_FILL_ADDR = 3'd3,
        REG_FILL_DATA = 3'd4,
        REG_CONTROL   = 3'd5
    } reg_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } dp_cmd_t;

endpackage

// File: rtl/bor_ctrl.sv
// Controller state machine of the bitmap overlay register file.
module bor_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output bor_pkg::dp_cmd_t cmd
);

    bor_pkg::ctl_state_t state_reg;
    bor_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bor_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        busy        = 1'b0;
        done        = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            bor_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = bor_pkg::ST_EXEC;
                end
            end
            bor_pkg::ST_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                state_next = bor_pkg::ST_DONE;
            end
            bor_pkg::ST_DONE:
            begin
                // The result is shown while the next item may already come in.
                done = 1'b1;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = bor_pkg::ST_EXEC;
                end
                else
                begin
                    state_next = bor_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bor_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/bor_datapath.sv
// Datapath of the bitmap overlay register file: registers, palette memory and result.
module bor_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bor_pkg::dp_cmd_t              cmd,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic [bor_pkg::OP_W-1:0]      operation,
    input  logic [bor_pkg::SEL_W-1:0]     reg_select,
    input  logic [bor_pkg::IDX_W-1:0]     palette_index,
    input  logic [bor_pkg::DATA_W-1:0]    write_data,
    input  logic                          hblank_in,
    input  logic                          vblank_in,
    output logic [bor_pkg::DATA_W-1:0]    read_data,
    output logic                          fill_valid,
    output logic [bor_pkg::DATA_W-1:0]    fill_start,
    output logic [bor_pkg::COUNT_W-1:0]   fill_count,
    output logic [bor_pkg::DATA_W-1:0]    fill_word
);

    // Captured item.
    bor_pkg::op_t                   op_reg;
    logic [bor_pkg::SEL_W-1:0]      sel_reg;
    logic [bor_pkg::IDX_W-1:0]      idx_reg;
    logic [bor_pkg::DATA_W-1:0]     wd_reg;
    logic                           hb_reg;
    logic                           vb_reg;

    // Architectural state.
    logic                           pal_region_reg;
    logic [bor_pkg::MODE_W-1:0]     mode_reg,         mode_next;
    logic [bor_pkg::DATA_W-1:0]     shift_reg,        shift_next;
    logic [bor_pkg::LEN_W-1:0]      fill_length_reg,  fill_length_next;
    logic [bor_pkg::DATA_W-1:0]     fill_address_reg, fill_address_next;
    logic [bor_pkg::DATA_W-1:0]     fill_data_reg,    fill_data_next;
    logic [bor_pkg::DATA_W-1:0]     control_reg,      control_next;
    logic                           pending_swap_reg, pending_swap_next;
    logic                           last_vblank_reg,  last_vblank_next;
    logic [bor_pkg::BUSY_CNT_W-1:0] busy_left_reg,    busy_left_next;

    // Palette memory with one valid bit per entry.
    logic [bor_pkg::DATA_W-1:0]        pal_mem [bor_pkg::PALETTE_DEPTH];
    logic [bor_pkg::PALETTE_DEPTH-1:0] pal_valid_reg;
    logic [bor_pkg::PAL_ADDR_W-1:0]    pal_addr;
    logic                              pal_in_range;
    logic [bor_pkg::DATA_W-1:0]        pal_rdata_reg;
    logic                              pal_hit_reg;

    // Result registers.
    logic [bor_pkg::DATA_W-1:0]  rd_reg,      rd_next;
    logic                        pal_read_reg, pal_read_next;
    logic                        fv_reg,      fv_next;
    logic [bor_pkg::DATA_W-1:0]  fs_reg,      fs_next;
    logic [bor_pkg::COUNT_W-1:0] fc_reg,      fc_next;
    logic [bor_pkg::DATA_W-1:0]  fw_reg,      fw_next;

    logic [bor_pkg::COUNT_W-1:0] count;
    logic [bor_pkg::LEN_W-1:0]   low_next;
    logic [bor_pkg::DATA_W-1:0]  blank_ctl;

    assign pal_addr     = idx_reg[bor_pkg::PAL_ADDR_W-1:0];
    assign pal_in_range = (32'(idx_reg) < bor_pkg::PALETTE_DEPTH);

    assign count    = {1'b0, fill_length_reg} + bor_pkg::COUNT_W'(1);
    assign low_next = fill_address_reg[bor_pkg::LEN_W-1:0] + count[bor_pkg::LEN_W-1:0];

    always_comb
    begin
        blank_ctl = control_reg;
        blank_ctl[bor_pkg::CTL_HBLK_BIT] = hb_reg;
        blank_ctl[bor_pkg::CTL_VBLK_BIT] = vb_reg;
        if (vb_reg && !last_vblank_reg)
        begin
            blank_ctl[bor_pkg::CTL_SWAP_BIT] = pending_swap_reg;
        end
    end

    always_comb
    begin
        mode_next         = mode_reg;
        shift_next        = shift_reg;
        fill_length_next  = fill_length_reg;
        fill_address_next = fill_address_reg;
        fill_data_next    = fill_data_reg;
        control_next      = control_reg;
        pending_swap_next = pending_swap_reg;
        last_vblank_next  = last_vblank_reg;
        busy_left_next    = busy_left_reg;
        rd_next           = '0;
        pal_read_next     = 1'b0;
        fv_next           = 1'b0;
        fs_next           = '0;
        fc_next           = '0;
        fw_next           = '0;

        unique case (op_reg)
            bor_pkg::OP_REG_READ:
            begin
                case (sel_reg)
                    bor_pkg::REG_MODE:      rd_next = {~pal_region_reg, mode_reg};
                    bor_pkg::REG_SHIFT:     rd_next = shift_reg;
                    bor_pkg::REG_FILL_LEN:  rd_next = bor_pkg::DATA_W'(fill_length_reg);
                    bor_pkg::REG_FILL_ADDR: rd_next = fill_address_reg;
                    bor_pkg::REG_FILL_DATA: rd_next = fill_data_reg;
                    bor_pkg::REG_CONTROL:
                    begin
                        rd_next = control_reg;
                        if (busy_left_reg != '0)
                        begin
                            rd_next[bor_pkg::CTL_BUSY_BIT] = 1'b1;
                            busy_left_next = busy_left_reg - bor_pkg::BUSY_CNT_W'(1);
                        end
                    end
                    default: rd_next = '0;
                endcase
            end
            bor_pkg::OP_REG_WRITE:
            begin
                case (sel_reg)
                    bor_pkg::REG_MODE:      mode_next = wd_reg[bor_pkg::MODE_W-1:0];
                    bor_pkg::REG_SHIFT:     shift_next = wd_reg;
                    bor_pkg::REG_FILL_LEN:  fill_length_next = wd_reg[bor_pkg::LEN_W-1:0];
                    bor_pkg::REG_FILL_ADDR: fill_address_next = wd_reg;
                    bor_pkg::REG_FILL_DATA: fill_data_next = wd_reg;
                    bor_pkg::REG_CONTROL:
                    begin
                        pending_swap_next = wd_reg[bor_pkg::CTL_SWAP_BIT];
                        if (control_reg[bor_pkg::CTL_VBLK_BIT])
                        begin
                            control_next[bor_pkg::CTL_SWAP_BIT] = wd_reg[bor_pkg::CTL_SWAP_BIT];
                        end
                    end
                    default: ;
                endcase
            end
            bor_pkg::OP_PAL_READ:
            begin
                pal_read_next = pal_in_range;
            end
            bor_pkg::OP_PAL_WRITE:
            begin
                // The memory write itself sits in the memory block below.
            end
            bor_pkg::OP_BLANK:
            begin
                control_next     = blank_ctl;
                last_vblank_next = vb_reg;
            end
            bor_pkg::OP_FILL:
            begin
                fv_next = 1'b1;
                fs_next = fill_address_reg;
                fc_next = count;
                fw_next = fill_data_reg;
                fill_address_next = {fill_address_reg[bor_pkg::DATA_W-1:bor_pkg::LEN_W],
                                     low_next};
                busy_left_next = bor_pkg::BUSY_CNT_W'(bor_pkg::BUSY_READ_COUNT);
            end
            default: ;
        endcase
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= bor_pkg::op_t'(operation);
            sel_reg <= reg_select;
            idx_reg <= palette_index;
            wd_reg  <= write_data;
            hb_reg  <= hblank_in;
            vb_reg  <= vblank_in;
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_region_reg   <= 1'b0;
            mode_reg         <= '0;
            shift_reg        <= '0;
            fill_length_reg  <= '0;
            fill_address_reg <= '0;
            fill_data_reg    <= '0;
            control_reg      <= '0;
            pending_swap_reg <= 1'b0;
            last_vblank_reg  <= 1'b0;
            busy_left_reg    <= '0;
            pal_valid_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                pal_region_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                mode_reg         <= mode_next;
                shift_reg        <= shift_next;
                fill_length_reg  <= fill_length_next;
                fill_address_reg <= fill_address_next;
                fill_data_reg    <= fill_data_next;
                control_reg      <= control_next;
                pending_swap_reg <= pending_swap_next;
                last_vblank_reg  <= last_vblank_next;
                busy_left_reg    <= busy_left_next;
                if (op_reg == bor_pkg::OP_PAL_WRITE && pal_in_range)
                begin
                    pal_valid_reg[pal_addr] <= 1'b1;
                end
            end
        end
    end

    // Palette memory, registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (op_reg == bor_pkg::OP_PAL_WRITE && pal_in_range)
            begin
                pal_mem[pal_addr] <= wd_reg;
            end
            pal_rdata_reg <= pal_mem[pal_addr];
            pal_hit_reg   <= pal_valid_reg[pal_addr];
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rd_reg       <= rd_next;
            pal_read_reg <= pal_read_next;
            fv_reg       <= fv_next;
            fs_reg       <= fs_next;
            fc_reg       <= fc_next;
            fw_reg       <= fw_next;
        end
    end

    assign read_data  = pal_read_reg ? (pal_hit_reg ? pal_rdata_reg : '0) : rd_reg;
    assign fill_valid = fv_reg;
    assign fill_start = fs_reg;
    assign fill_count = fc_reg;
    assign fill_word  = fw_reg;

endmodule

// File: rtl/bitmap_overlay_register_file_top.sv
// Top level of the bitmap overlay register file.
//
// Each item is one operation: a register read or write, a palette read or
// write, a blanking update or an autofill start. An item is taken at a rising
// edge where start is high and busy is low. Every item gives exactly one
// result. It is shown for one cycle with done high, in the cycle after the
// execute cycle. The receiver cannot stall it, so it must take the result in
// that cycle. busy is high only in the execute cycle, so a new item may be
// started in the same cycle in which the previous result is shown. The palette
// memory has a registered read port: an item reads it in the execute cycle,
// and its result is shown with done high. The region input (cfg_we,
// cfg_wdata) selects PAL when set, which makes bit 15 of the mode register
// read as zero; it should be written only while no item is in flight. An
// autofill writes no memory; it returns a fill descriptor and advances the
// low byte of the fill address within its row.
module bitmap_overlay_register_file_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic [bor_pkg::OP_W-1:0]      operation,
    input  logic [bor_pkg::SEL_W-1:0]     reg_select,
    input  logic [bor_pkg::IDX_W-1:0]     palette_index,
    input  logic [bor_pkg::DATA_W-1:0]    write_data,
    input  logic                          hblank_in,
    input  logic                          vblank_in,
    output logic [bor_pkg::DATA_W-1:0]    read_data,
    output logic                          fill_valid,
    output logic [bor_pkg::DATA_W-1:0]    fill_start,
    output logic [bor_pkg::COUNT_W-1:0]   fill_count,
    output logic [bor_pkg::DATA_W-1:0]    fill_word
);

    bor_pkg::dp_cmd_t cmd;

    // The controller sequences capture, execute and result cycles.
    bor_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds the register file, the palette and the result.
    bor_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .operation     (operation),
        .reg_select    (reg_select),
        .palette_index (palette_index),
        .write_data    (write_data),
        .hblank_in     (hblank_in),
        .vblank_in     (vblank_in),
        .read_data     (read_data),
        .fill_valid    (fill_valid),
        .fill_start    (fill_start),
        .fill_count    (fill_count),
        .fill_word     (fill_word)
    );

endmodule
